>>> rtl/asps_pkg.sv
package asps_pkg;

   // word widths of the ports
   localparam int IN_W  = 18;
   localparam int OUT_W = 18;

   // coefficients and pi/2, scaled by 1e9
   localparam longint unsigned NANO_A0      = 64'd1570728800;
   localparam longint unsigned NANO_A1      = 64'd212114400;
   localparam longint unsigned NANO_A2      = 64'd74261000;
   localparam longint unsigned NANO_A3      = 64'd18729300;
   localparam longint unsigned NANO_HALF_PI = 64'd1570796327;
   localparam longint unsigned NANO_ONE     = 64'd1000000000;

   // round a scaled-by-1e9 magnitude to the nearest step of 2^-frac_bits, ties up
   function automatic longint quant(input longint unsigned nano, input int frac_bits);
      longint unsigned m;
      m = (nano * (64'd1 << frac_bits) + NANO_ONE / 2) / NANO_ONE;
      return longint'(m);
   endfunction

endpackage

>>> rtl/asps_horner_stage.sv
module asps_horner_stage #(
   parameter int FRAC_BITS = 16,
   parameter int MW = 17,
   parameter int PW = 19,
   parameter int SW = 34,
   parameter logic signed [PW-1:0] COEF = '0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [MW-1:0]        in_mag,
   input  logic signed [PW-1:0] in_acc,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [MW-1:0]        out_mag,
   output logic signed [PW-1:0] out_acc,
   output logic [SW-1:0]        out_side
);
   localparam int XW = PW + MW + 1;

   logic                 valid_ff;
   logic [MW-1:0]        mag_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [PW-1:0] acc_in;
   logic [SW-1:0]        side_ff;
   logic signed [XW-1:0] prod;
   logic signed [XW-1:0] prod_sh;

   // one Horner step: floor(acc * mag / 2^F) + coefficient
   always_comb begin
      prod    = XW'(in_acc) * XW'($signed({1'b0, in_mag}));
      prod_sh = prod >>> FRAC_BITS;
      acc_in  = PW'(prod_sh) + COEF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= in_mag;
      acc_ff  <= acc_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_mag   = mag_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/asps_sqrt_cell.sv
module asps_sqrt_cell #(
   parameter int VW  = 33,
   parameter int POS = 16,
   parameter int SW  = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [VW-1:0] in_rem,
   input  logic [VW-1:0] in_root,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [VW-1:0] out_rem,
   output logic [VW-1:0] out_root,
   output logic [SW-1:0] out_side
);
   localparam logic [VW:0] BIT_C = (VW + 1)'(1) << (2 * POS);

   logic          valid_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] rem_in;
   logic [VW-1:0] root_ff;
   logic [VW-1:0] root_in;
   logic [SW-1:0] side_ff;
   logic [VW:0]   trial;

   // one restoring step of the integer square root at a fixed bit weight
   always_comb begin
      trial = (VW + 1)'(in_root) + BIT_C;
      if ((VW + 1)'(in_rem) >= trial) begin
         rem_in  = VW'((VW + 1)'(in_rem) - trial);
         root_in = VW'((VW + 1)'(in_root >> 1) + BIT_C);
      end else begin
         rem_in  = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/arcsine_poly_sqrt_approx.sv
// Arcsine approximation: angle = sign(x) * (pi/2 - sqrt(1 - |x|) * p(|x|)),
// p a cubic minimax polynomial, all in signed fixed point with FRAC_BITS
// fractional bits.
// Input: drive req_x_value and raise start; a word is taken at each rising
// edge with start high. busy is held low, so a word can enter every cycle.
// Output: rsp_strobe is high for exactly one cycle with rsp_angle valid; the
// receiver takes it in that cycle and cannot stall the block.
// Stages: one input stage, three Horner stages, FRAC_BITS + 1 square-root
// cells (one root bit each), a product stage and the output register lie
// between the accepting edge and the edge that takes the result. Throughput
// is one word per cycle.
// Reset clears every valid bit, so words in flight are dropped; the only other
// state that reset clears is the age counter.
module arcsine_poly_sqrt_approx #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [asps_pkg::IN_W-1:0]     req_x_value,
   output logic                                 rsp_strobe,
   output logic signed [asps_pkg::OUT_W-1:0]    rsp_angle
);
   import asps_pkg::*;

   localparam int MW    = FRAC_BITS + 1;
   localparam int PW    = FRAC_BITS + 3;
   localparam int VW    = 2 * FRAC_BITS + 1;
   localparam int CW    = (IN_W > MW) ? IN_W : MW;
   localparam int RW    = (PW > OUT_W) ? PW : OUT_W;
   localparam int NCELL = FRAC_BITS + 1;
   localparam int HSW   = VW + 1;
   localparam int CSW   = PW + 1;
   localparam int FW    = MW + PW + 1;
   localparam int LAT   = FRAC_BITS + 7;
   localparam int AW    = $clog2(LAT + 1);

   localparam logic signed [PW-1:0] C_A0 = PW'(quant(NANO_A0, FRAC_BITS));
   localparam logic signed [PW-1:0] C_A1 = PW'(-quant(NANO_A1, FRAC_BITS));
   localparam logic signed [PW-1:0] C_A2 = PW'(quant(NANO_A2, FRAC_BITS));
   localparam logic signed [PW-1:0] C_A3 = PW'(-quant(NANO_A3, FRAC_BITS));
   localparam logic signed [PW-1:0] C_HALF_PI = PW'(quant(NANO_HALF_PI, FRAC_BITS));
   localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
   localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

   // input stage: magnitude, sign, saturation at one
   logic             v0_ff;
   logic [MW-1:0]    mag0_ff;
   logic [MW-1:0]    mag0_in;
   logic             neg0_ff;
   logic             neg0_in;
   logic [IN_W-1:0]  mag_abs;
   logic [CW-1:0]    mag_ext;
   logic [VW-1:0]    rem0;

   assign busy = 1'b0;

   always_comb begin
      neg0_in = req_x_value[IN_W-1];
      mag_abs = neg0_in ? (~req_x_value + 1'b1) : req_x_value;
      mag_ext = CW'(mag_abs);
      mag0_in = (mag_ext > ONE_C) ? MW'(ONE_C) : MW'(mag_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      mag0_ff <= mag0_in;
      neg0_ff <= neg0_in;
   end

   // radicand (1 - |x|) << F rides alongside the polynomial
   assign rem0 = (ONE_V - VW'(mag0_ff)) << FRAC_BITS;

   // Horner stages
   logic                 h_valid [0:3];
   logic [MW-1:0]        h_mag   [0:3];
   logic signed [PW-1:0] h_acc   [0:3];
   logic [HSW-1:0]       h_side  [0:3];

   assign h_valid[0] = v0_ff;
   assign h_mag[0]   = mag0_ff;
   assign h_acc[0]   = C_A3;
   assign h_side[0]  = {neg0_ff, rem0};

   asps_horner_stage #(
      .FRAC_BITS(FRAC_BITS), .MW(MW), .PW(PW), .SW(HSW), .COEF(C_A2)
   ) u_horner_a2 (
      .clock(clock), .reset(reset),
      .in_valid(h_valid[0]), .in_mag(h_mag[0]), .in_acc(h_acc[0]), .in_side(h_side[0]),
      .out_valid(h_valid[1]), .out_mag(h_mag[1]), .out_acc(h_acc[1]),
      .out_side(h_side[1])
   );

   asps_horner_stage #(
      .FRAC_BITS(FRAC_BITS), .MW(MW), .PW(PW), .SW(HSW), .COEF(C_A1)
   ) u_horner_a1 (
      .clock(clock), .reset(reset),
      .in_valid(h_valid[1]), .in_mag(h_mag[1]), .in_acc(h_acc[1]), .in_side(h_side[1]),
      .out_valid(h_valid[2]), .out_mag(h_mag[2]), .out_acc(h_acc[2]),
      .out_side(h_side[2])
   );

   asps_horner_stage #(
      .FRAC_BITS(FRAC_BITS), .MW(MW), .PW(PW), .SW(HSW), .COEF(C_A0)
   ) u_horner_a0 (
      .clock(clock), .reset(reset),
      .in_valid(h_valid[2]), .in_mag(h_mag[2]), .in_acc(h_acc[2]), .in_side(h_side[2]),
      .out_valid(h_valid[3]), .out_mag(h_mag[3]), .out_acc(h_acc[3]),
      .out_side(h_side[3])
   );

   // square-root cell chain, one root bit per cell, most significant first
   logic           c_valid [0:NCELL];
   logic [VW-1:0]  c_rem   [0:NCELL];
   logic [VW-1:0]  c_root  [0:NCELL];
   logic [CSW-1:0] c_side  [0:NCELL];

   assign c_valid[0] = h_valid[3];
   assign c_rem[0]   = h_side[3][VW-1:0];
   assign c_root[0]  = '0;
   assign c_side[0]  = {h_side[3][VW], h_acc[3]};

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      asps_sqrt_cell #(
         .VW(VW), .POS(FRAC_BITS - k), .SW(CSW)
      ) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(c_valid[k]), .in_rem(c_rem[k]), .in_root(c_root[k]),
         .in_side(c_side[k]),
         .out_valid(c_valid[k+1]), .out_rem(c_rem[k+1]), .out_root(c_root[k+1]),
         .out_side(c_side[k+1])
      );
   end

   // product stage: sqrt * polynomial
   logic                 fv_ff;
   logic                 fneg_ff;
   logic signed [FW-1:0] fprod_ff;
   logic signed [FW-1:0] fprod_in;
   logic [MW-1:0]        root_s;
   logic signed [PW-1:0] poly_p;

   always_comb begin
      root_s   = c_root[NCELL][MW-1:0];
      poly_p   = c_side[NCELL][PW-1:0];
      fprod_in = FW'($signed({1'b0, root_s})) * FW'(poly_p);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= c_valid[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      fprod_ff <= fprod_in;
      fneg_ff  <= c_side[NCELL][PW];
   end

   // output stage: pi/2 minus product, sign of x applied
   logic                    out_v_ff;
   logic [OUT_W-1:0]        angle_ff;
   logic [OUT_W-1:0]        angle_in;
   logic signed [FW-1:0]    fprod_sh;
   logic signed [PW-1:0]    r_mag;
   logic signed [PW-1:0]    r_sgn;
   logic signed [RW-1:0]    r_ext;

   always_comb begin
      fprod_sh = fprod_ff >>> FRAC_BITS;
      r_mag    = C_HALF_PI - PW'(fprod_sh);
      r_sgn    = fneg_ff ? -r_mag : r_mag;
      r_ext    = RW'(r_sgn);
      angle_in = r_ext[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= fv_ff;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_angle  = $signed(angle_ff);

   // cycles since reset, saturating at the pipeline depth
   logic [AW-1:0] age_ff;
   logic [AW-1:0] age_in;

   assign age_in = (age_ff == AW'(LAT)) ? age_ff : age_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= '0;
      end else begin
         age_ff <= age_in;
      end
   end

   // every accepted word comes out as a result strobe, and nothing else
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (age_ff == AW'(LAT)) |-> (rsp_strobe == $past(start, LAT)))
      else $error("result strobe does not match accepted word");

   // magnitude is saturated at one
   a_mag_sat: assert property (@(posedge clock) disable iff (reset)
      v0_ff |-> (CW'(mag0_ff) <= ONE_C))
      else $error("magnitude above one after saturation");

   // square root of a radicand at most 2^(2F) never exceeds 2^F
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      c_valid[NCELL] |-> (c_root[NCELL] <= ONE_V))
      else $error("square root out of range");

endmodule

>>> sim/arcsine_poly_sqrt_approx_checker.sv
`timescale 1ns / 100ps

module arcsine_poly_sqrt_approx_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic signed [asps_pkg::IN_W-1:0]     req_x_value,
   input  logic                                 rsp_strobe,
   input  logic signed [asps_pkg::OUT_W-1:0]    rsp_angle,
   output int                                   mismatch_count,
   output int                                   angles_pending
);

   import asps_pkg::*;

   // coefficient magnitudes and pi/2, in units of 1e-9
   localparam longint unsigned A0_E9      = 64'd1570728800;
   localparam longint unsigned A1_E9      = 64'd212114400;
   localparam longint unsigned A2_E9      = 64'd74261000;
   localparam longint unsigned A3_E9      = 64'd18729300;
   localparam longint unsigned HALF_PI_E9 = 64'd1570796327;
   localparam longint unsigned UNIT_E9    = 64'd1000000000;

   typedef struct packed {
      logic signed [IN_W-1:0]  x_value;
      logic signed [OUT_W-1:0] angle;
   } angle_due_type;

   angle_due_type angle_due[$];

   // magnitude rounded to the nearest LSB, ties up
   function automatic longint coef_fixed(input longint unsigned mag_e9);
      return longint'((mag_e9 * (64'd1 << FRAC_BITS) + UNIT_E9 / 2) / UNIT_E9);
   endfunction

   // rounded-down integer square root, one root bit per pass
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v)
         probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // sign(x) * (pi/2 - sqrt(1 - |x|) * p(|x|)), floor after every product
   function automatic logic signed [OUT_W-1:0] arcsine_fixed(
      input logic signed [IN_W-1:0] x);
      longint one;
      longint mag;
      longint poly;
      longint root;
      longint r;
      one = longint'(1) << FRAC_BITS;
      mag = longint'(x);
      if (mag < 0)
         mag = -mag;
      // beyond +-1.0 saturates to 1.0
      if (mag > one)
         mag = one;
      poly = -coef_fixed(A3_E9);
      poly = ((poly * mag) >>> FRAC_BITS) + coef_fixed(A2_E9);
      poly = ((poly * mag) >>> FRAC_BITS) - coef_fixed(A1_E9);
      poly = ((poly * mag) >>> FRAC_BITS) + coef_fixed(A0_E9);
      root = longint'(int_sqrt(longint'(one - mag) << FRAC_BITS));
      r = coef_fixed(HALF_PI_E9) - ((root * poly) >>> FRAC_BITS);
      // zero stays positive
      if (x < 0)
         r = -r;
      return r[OUT_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      angles_pending = 0;
   end

   // compare results first, then log the word taken at this edge
   always @(posedge clock) begin
      angle_due_type head;
      if (!reset) begin
         if (rsp_strobe) begin
            if (angle_due.size() == 0) begin
               report_mismatch($sformatf("unexpected angle %0d", rsp_angle));
            end else begin
               head = angle_due.pop_front();
               if (rsp_angle !== head.angle)
                  report_mismatch($sformatf("x %0d: angle %0d, predicted %0d",
                                            head.x_value, rsp_angle, head.angle));
            end
         end
         if (start && !busy)
            angle_due.push_back('{x_value: req_x_value,
                                  angle: arcsine_fixed(req_x_value)});
      end
      angles_pending = angle_due.size();
   end

endmodule

>>> sim/arcsine_poly_sqrt_approx_tb.sv
`timescale 1ns / 100ps

module arcsine_poly_sqrt_approx_tb;

   import asps_pkg::*;

   localparam int FRAC_BITS    = 16;
   localparam int ONE          = 1 << FRAC_BITS;
   localparam int RANDOM_WORDS = 450;
   localparam int DRAIN_CYCLES = FRAC_BITS + 7 + 20;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [IN_W-1:0]  req_x_value;
   logic                    rsp_strobe;
   logic signed [OUT_W-1:0] rsp_angle;
   int                      mismatch_count;
   int                      angles_pending;

   arcsine_poly_sqrt_approx #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_x_value(req_x_value),
      .rsp_strobe (rsp_strobe),
      .rsp_angle  (rsp_angle)
   );

   arcsine_poly_sqrt_approx_checker #(
      .FRAC_BITS(FRAC_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_x_value   (req_x_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_angle     (rsp_angle),
      .mismatch_count(mismatch_count),
      .angles_pending(angles_pending)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop
   initial begin
      #500000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // idle cycle by cycle at the given percentage, then present one word at the
   // falling edge and hold until the block takes it
   task automatic send_word(input logic signed [IN_W-1:0] x, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_x_value <= x;
      do @(posedge clock); while (busy);
   endtask

   // random sample: mostly in range, extra weight near 0 and +-1, a few beyond
   function automatic logic signed [IN_W-1:0] random_sine();
      int pick;
      int mag;
      pick = $urandom_range(99);
      if (pick < 55)
         mag = $urandom_range(ONE);
      else if (pick < 70)
         mag = ONE - $urandom_range(255);
      else if (pick < 80)
         mag = $urandom_range(255);
      else if (pick < 92)
         mag = ONE - $urandom_range(ONE / 16);
      else
         mag = $urandom_range((1 << (IN_W - 1)) - 1, ONE + 1);
      if ($urandom_range(1) == 1)
         return IN_W'(-mag);
      return IN_W'(mag);
   endfunction

   // directed words: zero, +-LSB, +-1.0, just below and beyond one, mid points
   int directed_x[] = '{0, 1, -1, ONE, -ONE, ONE - 1, -(ONE - 1), ONE / 2, -(ONE / 2),
                        ONE / 4, -(ONE / 4), 3 * ONE / 4, -(3 * ONE / 4), ONE + 1,
                        -(ONE + 1), (1 << (IN_W - 1)) - 1, -(1 << (IN_W - 1)),
                        100, -100, ONE - 256};

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_x_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_x[i])
         send_word(IN_W'(directed_x[i]), 0);

      // sender idles lightly, then heavily, then never
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i < RANDOM_WORDS / 3)
            send_word(random_sine(), 10);
         else if (i < 2 * RANDOM_WORDS / 3)
            send_word(random_sine(), 67);
         else
            send_word(random_sine(), 0);
      end
      @(negedge clock);
      start <= 1'b0;

      wait (angles_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
